@@ src/kfce_pkg.sv @@
// Package of the k-feasible cut enumerator: shared leaf, cut and payload types,
// operation and register codes, and the sequencer state type. No dependencies.
`default_nettype none

package kfce_pkg;

  localparam int MAX_LEAVES = 6;
  localparam int ID_W       = 16;
  localparam int LCNT_W     = 3;

  typedef logic [ID_W-1:0]             leaf_id_t;
  typedef leaf_id_t [MAX_LEAVES-1:0]   leaf_set_t;
  typedef logic [LCNT_W-1:0]           leaf_cnt_t;

  localparam logic [1:0] OP_LOAD_LEFT  = 2'd0;
  localparam logic [1:0] OP_LOAD_RIGHT = 2'd1;
  localparam logic [1:0] OP_COMPUTE    = 2'd2;

  localparam logic [1:0] CFG_CUT_SIZE_LIMIT = 2'd0;
  localparam logic [1:0] CFG_MAX_CUTS       = 2'd1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [2:0]  leaf_count;
    logic [15:0] leaf_a;
    logic [15:0] leaf_b;
    logic [15:0] leaf_c;
    logic [15:0] leaf_d;
    logic [15:0] leaf_e;
    logic [15:0] leaf_f;
    logic [15:0] node_id;
  } item_t;

  typedef struct packed {
    logic [2:0]  out_count;
    logic [15:0] out_a;
    logic [15:0] out_b;
    logic [15:0] out_c;
    logic [15:0] out_d;
    logic [15:0] out_e;
    logic [15:0] out_f;
    logic        last_cut;
    logic        saturated;
  } cut_t;

  typedef struct packed {
    leaf_cnt_t size;
    leaf_set_t leaves;
  } cut_entry_t;

  typedef struct packed {
    logic       en;
    cut_entry_t entry;
  } store_wr_t;

  typedef enum logic [1:0] {
    M_EQUAL,
    M_SUBSET,
    M_MERGE
  } unite_mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_L,
    S_SCAN_R,
    S_PHASE,
    S_SETUP,
    S_CHECK,
    S_UNITE,
    S_FILTER,
    S_PRUNE,
    S_APPEND,
    S_NEXT,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

@@ src/kfce_subset_unit.sv @@
// Shared containment unit: tells whether every leaf of one cut occurs in another.
// Depends on kfce_pkg for the leaf set and count types.
`default_nettype none

module kfce_subset_unit import kfce_pkg::*; (
  input  leaf_set_t sub_set,
  input  leaf_cnt_t sub_cnt,
  input  leaf_set_t sup_set,
  input  leaf_cnt_t sup_cnt,
  output logic      contained
);

  always_comb begin
    logic found;
    contained = 1'b1;
    for (int i = 0; i < MAX_LEAVES; i++) begin
      found = 1'b0;
      for (int j = 0; j < MAX_LEAVES; j++) begin
        if (j < int'(sup_cnt) && sub_set[i] == sup_set[j]) begin
          found = 1'b1;
        end
      end
      if (i < int'(sub_cnt) && !found) begin
        contained = 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/kfce_fanin_store.sv @@
// Fanin cut list: appends loaded cuts at its fill count, one read port.
// Depends on kfce_pkg for the cut entry and write types.
`default_nettype none

module kfce_fanin_store import kfce_pkg::*; #(
  parameter int MAX_CUTS = 32,
  localparam int IDX_W = $clog2(MAX_CUTS),
  localparam int CNT_W = $clog2(MAX_CUTS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  store_wr_t        wr,
  input  logic             clear,
  input  logic [IDX_W-1:0] rd_addr,
  output cut_entry_t       rd_entry,
  output logic [CNT_W-1:0] fill
);

  cut_entry_t mem [MAX_CUTS];
  logic       room;

  assign room = (fill < CNT_W'(MAX_CUTS));

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (clear) begin
      fill <= '0;
    end else if (wr.en && room) begin
      fill <= fill + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && room) begin
      mem[fill[IDX_W-1:0]] <= wr.entry;
    end
  end

  assign rd_entry = mem[rd_addr];

endmodule

`default_nettype wire

@@ src/kfce_result_store.sv @@
// Result cut list of the node under work: one write and one read address.
// Depends on kfce_pkg for the cut entry and write types.
`default_nettype none

module kfce_result_store import kfce_pkg::*; #(
  parameter int MAX_CUTS = 32,
  localparam int IDX_W = $clog2(MAX_CUTS)
) (
  input  logic             clk,
  input  store_wr_t        wr,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [IDX_W-1:0] rd_addr,
  output cut_entry_t       rd_entry
);

  cut_entry_t mem [MAX_CUTS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.entry;
    end
  end

  assign rd_entry = mem[rd_addr];

endmodule

`default_nettype wire

@@ src/kfeasible_cut_enumerator_core.sv @@
// Top level of the k-feasible cut enumerator: sequencer, merge datapath, emit stage.
// Depends on kfce_pkg, kfce_fanin_store, kfce_result_store and kfce_subset_unit.
`default_nettype none

// Channel   Direction  Handshake              Payload
// item      in         item_valid/item_stall  item_t: load left, load right or compute
// cut       out        cut_valid/cut_stall    cut_t: one emitted cut of the node
// cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_value (K and C registers)
//
// A load transaction appends its cut to its fanin list while that list has room. A compute
// transaction first scans both fanin lists for the start of their K-leaf parts, then for each
// fanin pair, until the result list reaches C cuts, sets the pair up, unites it (equality,
// containment or a merge of up to K leaves) and makes two passes over the result list (filter,
// then prune), and finally scans the result list once per cut size. One containment unit serves
// every check and the merge places one leaf per step. item_stall is high from the compute until
// its last cut has entered the output register. A stalled cut output holds the scan; rst is
// synchronous, active high, and returns K to 4, C to 16 and empties all lists.

module kfeasible_cut_enumerator_core import kfce_pkg::*; #(
  parameter int MAX_CUTS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  item_t      item,
  output logic       cut_valid,
  input  logic       cut_stall,
  output cut_t       cut,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [5:0] cfg_value
);

  localparam int IDX_W = $clog2(MAX_CUTS);
  localparam int CNT_W = $clog2(MAX_CUTS + 1);

  state_t state, state_next;

  // Configuration registers and their clamped values.
  logic [2:0]       cfg_k;
  logic [5:0]       cfg_c;
  leaf_cnt_t        k_eff;
  logic [CNT_W-1:0] c_eff;

  // Fanin stores.
  store_wr_t        lwr, rwr;
  cut_entry_t       load_entry;
  logic             fanin_clear;
  logic [IDX_W-1:0] l_addr, r_addr;
  cut_entry_t       l_rd, r_rd;
  logic [CNT_W-1:0] lfill, rfill;

  // Result store.
  store_wr_t        res_wr;
  logic [IDX_W-1:0] res_wr_addr;
  cut_entry_t       res_rd;
  logic [CNT_W-1:0] total;

  // Scan and pair counters.
  logic [CNT_W-1:0] e, w, i, j, lb, rb;
  logic [1:0]       phase;
  logic             sat;
  logic [CNT_W-1:0] i_lo, i_hi, j_lo, j_hi;
  logic             pair_any;
  logic             phase_done;
  logic [CNT_W-1:0] i_adv, j_adv;

  // Union datapath.
  leaf_set_t        ua, ub, res;
  leaf_cnt_t        una, unb, mi, mj, ml, rcnt;
  unite_mode_t      mode, setup_mode;
  logic             swap;
  logic             eq_ok;
  logic             merge_ok, merge_fail;
  logic             take_a, take_b;
  leaf_id_t         a_cur, b_cur, merge_val;

  // Shared containment unit operands.
  leaf_set_t        sub_set, sup_set;
  leaf_cnt_t        sub_cnt, sup_cnt;
  logic             contained;
  logic             reject, drop;

  // Emit stage.
  leaf_cnt_t        es;
  cut_entry_t       pend;
  logic             pend_valid;
  logic             em_match, exhausted, out_free;
  logic             cut_load;
  logic             in_take;

  function automatic cut_t make_cut(cut_entry_t ent, logic last, logic s);
    cut_t c;
    c.out_count = ent.size;
    c.out_a     = ent.leaves[0];
    c.out_b     = ent.leaves[1];
    c.out_c     = ent.leaves[2];
    c.out_d     = ent.leaves[3];
    c.out_e     = ent.leaves[4];
    c.out_f     = ent.leaves[5];
    c.last_cut  = last;
    c.saturated = s;
    return c;
  endfunction

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != S_IDLE);
  assign in_take    = item_valid && !item_stall;

  // K and C saturate into their legal ranges.
  always_comb begin
    if (cfg_k < 3'd2) begin
      k_eff = 3'd2;
    end else if (int'(cfg_k) > MAX_LEAVES) begin
      k_eff = LCNT_W'(MAX_LEAVES);
    end else begin
      k_eff = cfg_k;
    end
    if (cfg_c < 6'd2) begin
      c_eff = CNT_W'(2);
    end else if (int'(cfg_c) > MAX_CUTS) begin
      c_eff = CNT_W'(MAX_CUTS);
    end else begin
      c_eff = CNT_W'(cfg_c);
    end
  end

  // A loaded cut keeps its leaves up to the clamped count; later leaf slots are zero.
  always_comb begin
    leaf_cnt_t cnt;
    leaf_set_t lv;
    cnt = item.leaf_count;
    if (cnt == 3'd0) begin
      cnt = 3'd1;
    end else if (int'(cnt) > MAX_LEAVES) begin
      cnt = LCNT_W'(MAX_LEAVES);
    end
    lv[0] = item.leaf_a;
    lv[1] = item.leaf_b;
    lv[2] = item.leaf_c;
    lv[3] = item.leaf_d;
    lv[4] = item.leaf_e;
    lv[5] = item.leaf_f;
    for (int f = 0; f < MAX_LEAVES; f++) begin
      if (f >= int'(cnt)) begin
        lv[f] = '0;
      end
    end
    load_entry.size   = cnt;
    load_entry.leaves = lv;
  end

  assign lwr.en    = in_take && (item.operation == OP_LOAD_LEFT);
  assign lwr.entry = load_entry;
  assign rwr.en    = in_take && (item.operation == OP_LOAD_RIGHT);
  assign rwr.entry = load_entry;

  assign l_addr = (state == S_SCAN_L) ? e[IDX_W-1:0] : i[IDX_W-1:0];
  assign r_addr = (state == S_SCAN_R) ? e[IDX_W-1:0] : j[IDX_W-1:0];

  kfce_fanin_store #(.MAX_CUTS(MAX_CUTS)) u_left (
    .clk      (clk),
    .rst      (rst),
    .wr       (lwr),
    .clear    (fanin_clear),
    .rd_addr  (l_addr),
    .rd_entry (l_rd),
    .fill     (lfill)
  );

  kfce_fanin_store #(.MAX_CUTS(MAX_CUTS)) u_right (
    .clk      (clk),
    .rst      (rst),
    .wr       (rwr),
    .clear    (fanin_clear),
    .rd_addr  (r_addr),
    .rd_entry (r_rd),
    .fill     (rfill)
  );

  // The four pair phases: small x small, left small x right large,
  // right small x left large (left index runs inner), large x large.
  always_comb begin
    unique case (phase)
      2'd0: begin
        i_lo = '0; i_hi = lb; j_lo = '0; j_hi = rb;
      end
      2'd1: begin
        i_lo = '0; i_hi = lb; j_lo = rb; j_hi = rfill;
      end
      2'd2: begin
        i_lo = lb; i_hi = lfill; j_lo = '0; j_hi = rb;
      end
      default: begin
        i_lo = lb; i_hi = lfill; j_lo = rb; j_hi = rfill;
      end
    endcase
    pair_any = (i_lo < i_hi) && (j_lo < j_hi);
  end

  always_comb begin
    i_adv      = i;
    j_adv      = j;
    phase_done = 1'b0;
    if (phase == 2'd2) begin
      if (i + 1'b1 < i_hi) begin
        i_adv = i + 1'b1;
      end else begin
        i_adv = i_lo;
        j_adv = j + 1'b1;
        phase_done = (j + 1'b1 >= j_hi);
      end
    end else begin
      if (j + 1'b1 < j_hi) begin
        j_adv = j + 1'b1;
      end else begin
        j_adv = j_lo;
        i_adv = i + 1'b1;
        phase_done = (i + 1'b1 >= i_hi);
      end
    end
  end

  // Pair setup: the larger cut goes first; ties keep the left cut first.
  always_comb begin
    leaf_cnt_t na;
    leaf_cnt_t nb;
    swap = (l_rd.size < r_rd.size);
    na   = swap ? r_rd.size : l_rd.size;
    nb   = swap ? l_rd.size : r_rd.size;
    if (na == k_eff && nb == k_eff) begin
      setup_mode = M_EQUAL;
    end else if (na == k_eff) begin
      setup_mode = M_SUBSET;
    end else begin
      setup_mode = M_MERGE;
    end
  end

  always_comb begin
    eq_ok = 1'b1;
    for (int x = 0; x < MAX_LEAVES; x++) begin
      if (x < int'(k_eff) && ua[x] != ub[x]) begin
        eq_ok = 1'b0;
      end
    end
  end

  // One step of the sorted merge, one leaf per cycle.
  always_comb begin
    a_cur      = ua[mi];
    b_cur      = ub[mj];
    merge_ok   = (mi == una) && (mj == unb);
    merge_fail = !merge_ok && (ml == k_eff);
    take_a     = 1'b0;
    take_b     = 1'b0;
    merge_val  = a_cur;
    if (mj == unb) begin
      take_a = 1'b1;
    end else if (mi == una) begin
      take_b    = 1'b1;
      merge_val = b_cur;
    end else if (a_cur < b_cur) begin
      take_a = 1'b1;
    end else if (a_cur > b_cur) begin
      take_b    = 1'b1;
      merge_val = b_cur;
    end else begin
      take_a = 1'b1;
      take_b = 1'b1;
    end
  end

  // The containment unit serves the subset form of the union, the filter pass
  // (stored cut inside the new one) and the prune pass (new cut inside a stored one).
  always_comb begin
    unique case (state)
      S_CHECK: begin
        sub_set = ub;         sub_cnt = unb;
        sup_set = ua;         sup_cnt = una;
      end
      S_FILTER: begin
        sub_set = res_rd.leaves; sub_cnt = res_rd.size;
        sup_set = res;           sup_cnt = rcnt;
      end
      default: begin
        sub_set = res;           sub_cnt = rcnt;
        sup_set = res_rd.leaves; sup_cnt = res_rd.size;
      end
    endcase
  end

  kfce_subset_unit u_subset (
    .sub_set   (sub_set),
    .sub_cnt   (sub_cnt),
    .sup_set   (sup_set),
    .sup_cnt   (sup_cnt),
    .contained (contained)
  );

  // Size-one cuts never filter; only stored cuts of K leaves or fewer are pruned.
  assign reject = (res_rd.size >= 3'd2) && (res_rd.size <= rcnt) && contained;
  assign drop   = (res_rd.size > rcnt) && (res_rd.size <= k_eff) && contained;

  // Emit scan by size, then by insertion order.
  assign exhausted = (int'(es) > MAX_LEAVES);
  assign em_match  = !exhausted && (e < total) && (res_rd.size == es);
  assign out_free  = !cut_valid || !cut_stall;
  assign fanin_clear = (state == S_EMIT) && exhausted && out_free;

  // The output register loads when a held cut is pushed out by the next match,
  // or when the scan has ended and the held cut leaves as the last one.
  assign cut_load = (state == S_EMIT) && out_free &&
                    (exhausted || (em_match && pend_valid));

  // Result store write port.
  always_comb begin
    leaf_set_t triv;
    triv        = '0;
    triv[0]     = item.node_id;
    res_wr.en    = 1'b0;
    res_wr.entry = res_rd;
    res_wr_addr  = w[IDX_W-1:0];
    unique case (state)
      S_IDLE: begin
        res_wr.en           = in_take && (item.operation == OP_COMPUTE);
        res_wr.entry.size   = 3'd1;
        res_wr.entry.leaves = triv;
        res_wr_addr         = '0;
      end
      S_PRUNE: begin
        res_wr.en = (e < total) && !drop;
      end
      S_APPEND: begin
        res_wr.en           = 1'b1;
        res_wr.entry.size   = rcnt;
        res_wr.entry.leaves = res;
      end
      default: begin
        res_wr.en = 1'b0;
      end
    endcase
  end

  kfce_result_store #(.MAX_CUTS(MAX_CUTS)) u_result (
    .clk      (clk),
    .wr       (res_wr),
    .wr_addr  (res_wr_addr),
    .rd_addr  (e[IDX_W-1:0]),
    .rd_entry (res_rd)
  );

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_take && item.operation == OP_COMPUTE) begin
          state_next = S_SCAN_L;
        end
      end
      S_SCAN_L: begin
        if (e >= lfill || l_rd.size == k_eff) begin
          state_next = S_SCAN_R;
        end
      end
      S_SCAN_R: begin
        if (e >= rfill || r_rd.size == k_eff) begin
          state_next = S_PHASE;
        end
      end
      S_PHASE: begin
        if (pair_any) begin
          state_next = S_SETUP;
        end else if (phase == 2'd3) begin
          state_next = S_EMIT;
        end
      end
      S_SETUP: begin
        state_next = (setup_mode == M_MERGE) ? S_UNITE : S_CHECK;
      end
      S_CHECK: begin
        if ((mode == M_EQUAL) ? eq_ok : contained) begin
          state_next = S_FILTER;
        end else begin
          state_next = S_NEXT;
        end
      end
      S_UNITE: begin
        if (merge_ok) begin
          state_next = S_FILTER;
        end else if (merge_fail) begin
          state_next = S_NEXT;
        end
      end
      S_FILTER: begin
        if (e >= total) begin
          state_next = S_PRUNE;
        end else if (reject) begin
          state_next = S_NEXT;
        end
      end
      S_PRUNE: begin
        if (e >= total) begin
          state_next = (w >= CNT_W'(MAX_CUTS)) ? S_EMIT : S_APPEND;
        end
      end
      S_APPEND: begin
        state_next = (w + 1'b1 >= c_eff) ? S_EMIT : S_NEXT;
      end
      S_NEXT: begin
        if (!phase_done) begin
          state_next = S_SETUP;
        end else if (phase == 2'd3) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_PHASE;
        end
      end
      S_EMIT: begin
        if (exhausted && out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_k <= 3'd4;
      cfg_c <= 6'd16;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CUT_SIZE_LIMIT: cfg_k <= cfg_value[2:0];
        CFG_MAX_CUTS:       cfg_c <= cfg_value;
        default:            cfg_k <= cfg_k;
      endcase
    end
  end

  // Output valid: set when the register loads, cleared once the cut is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      cut_valid <= 1'b0;
    end else if (cut_load) begin
      cut_valid <= 1'b1;
    end else if (!cut_stall) begin
      cut_valid <= 1'b0;
    end
  end

  // Control registers that reset clears.
  always_ff @(posedge clk) begin
    if (rst) begin
      total      <= '0;
      pend_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_take && item.operation == OP_COMPUTE) begin
            total <= CNT_W'(1);
          end
        end
        S_PRUNE: begin
          if (e >= total) begin
            total <= w;
          end
        end
        S_APPEND: begin
          total <= w + 1'b1;
        end
        S_EMIT: begin
          if (!exhausted) begin
            if (em_match && !(pend_valid && !out_free)) begin
              pend_valid <= 1'b1;
            end
          end else if (out_free) begin
            pend_valid <= 1'b0;
          end
        end
        default: begin
          total <= total;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        e     <= '0;
        sat   <= 1'b0;
        phase <= 2'd0;
      end
      S_SCAN_L: begin
        if (e >= lfill || l_rd.size == k_eff) begin
          lb <= e;
          e  <= '0;
        end else begin
          e <= e + 1'b1;
        end
      end
      S_SCAN_R: begin
        if (e >= rfill || r_rd.size == k_eff) begin
          rb <= e;
          e  <= '0;
        end else begin
          e <= e + 1'b1;
        end
      end
      S_PHASE: begin
        if (pair_any) begin
          i <= i_lo;
          j <= j_lo;
        end else if (phase != 2'd3) begin
          phase <= phase + 1'b1;
        end
      end
      S_SETUP: begin
        ua   <= swap ? r_rd.leaves : l_rd.leaves;
        ub   <= swap ? l_rd.leaves : r_rd.leaves;
        una  <= swap ? r_rd.size : l_rd.size;
        unb  <= swap ? l_rd.size : r_rd.size;
        mode <= setup_mode;
        res  <= '0;
        mi   <= '0;
        mj   <= '0;
        ml   <= '0;
      end
      S_CHECK: begin
        res  <= ua;
        rcnt <= una;
        e    <= '0;
      end
      S_UNITE: begin
        if (merge_ok) begin
          rcnt <= ml;
          e    <= '0;
        end else if (!merge_fail) begin
          res[ml] <= merge_val;
          ml      <= ml + 1'b1;
          if (take_a) begin
            mi <= mi + 1'b1;
          end
          if (take_b) begin
            mj <= mj + 1'b1;
          end
        end
      end
      S_FILTER: begin
        if (e >= total) begin
          e <= '0;
          w <= '0;
        end else begin
          e <= e + 1'b1;
        end
      end
      S_PRUNE: begin
        if (e >= total) begin
          if (w >= CNT_W'(MAX_CUTS)) begin
            sat <= 1'b1;
          end
        end else begin
          e <= e + 1'b1;
          if (!drop) begin
            w <= w + 1'b1;
          end
        end
      end
      S_APPEND: begin
        if (w + 1'b1 >= c_eff) begin
          sat <= 1'b1;
        end
      end
      S_NEXT: begin
        i <= i_adv;
        j <= j_adv;
        if (phase_done && phase != 2'd3) begin
          phase <= phase + 1'b1;
        end
      end
      S_EMIT: begin
        if (!exhausted && !(em_match && pend_valid && !out_free)) begin
          if (em_match) begin
            pend <= res_rd;
            if (pend_valid) begin
              cut <= make_cut(pend, 1'b0, sat);
            end
          end
          if (e >= total) begin
            e  <= '0;
            es <= es + 1'b1;
          end else begin
            e <= e + 1'b1;
          end
        end else if (exhausted && out_free) begin
          cut <= make_cut(pend, 1'b1, sat);
        end
      end
      default: begin
        e <= e;
      end
    endcase
    // Entering the emit scan starts it at size one, first entry.
    if (state != S_EMIT && state_next == S_EMIT) begin
      es <= 3'd1;
      e  <= '0;
    end
  end

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= CNT_W'(MAX_CUTS))
    else $error("result list holds more cuts than its depth");

  a_prune_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_PRUNE) |-> (w <= e))
    else $error("compaction write pointer passed the read pointer");

  a_last_pending: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && exhausted) |-> pend_valid)
    else $error("emit scan ended with no cut held for the last transaction");

  a_cut_count: assert property (@(posedge clk) disable iff (rst)
    cut_valid |-> (cut.out_count != 3'd0 && int'(cut.out_count) <= MAX_LEAVES))
    else $error("emitted cut has an illegal leaf count");

endmodule

`default_nettype wire
